@@ hdl/cayley_matrix_hash_p128_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the matrix hash unit
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CAYLEY_MATRIX_HASH_P128_UNIT_MACROS_SVH
`define CAYLEY_MATRIX_HASH_P128_UNIT_MACROS_SVH

// same-cycle implication
`define CMH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cmh_pkg.sv @@
// ----------------------------------------------------------------------------
// cmh_pkg
// Types, field constants and generator coefficients for the matrix hash.
// ----------------------------------------------------------------------------
`default_nettype none

package cmh_pkg;

   localparam int FIELD_W = 128;

   // p = 2^128 - 15449
   localparam logic [FIELD_W-1:0] PRIME =
      128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_C3A7;
   // p - 2, exponent for inversion
   localparam logic [FIELD_W-1:0] INV_EXP =
      128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_C3A5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] bit_count;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic dbl;
      logic add_en;
      logic sub;
   } alu_ctrl_type;

   // magnitude of generator coefficient; idx is row-major y0..y3
   function automatic logic [2:0] coef_mag(input logic gbit, input logic [1:0] idx);
      logic [2:0] m;
      unique case ({gbit, idx})
         3'b000: m = 3'd2;
         3'b001: m = 3'd4;
         3'b010: m = 3'd1;
         3'b011: m = 3'd3;
         3'b100: m = 3'd5;
         3'b101: m = 3'd6;
         3'b110: m = 3'd2;
         3'b111: m = 3'd2;
      endcase
      return m;
   endfunction

   function automatic logic coef_neg(input logic gbit, input logic [1:0] idx);
      logic n;
      unique case ({gbit, idx})
         3'b000: n = 1'b1;
         3'b001: n = 1'b0;
         3'b010: n = 1'b0;
         3'b011: n = 1'b1;
         3'b100: n = 1'b1;
         3'b101: n = 1'b1;
         3'b110: n = 1'b0;
         3'b111: n = 1'b0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cmh_field_alu.sv @@
// ----------------------------------------------------------------------------
// cmh_field_alu
// Accumulator with one modular double-and-add/subtract step per cycle while ctrl.step is set.
// ----------------------------------------------------------------------------
`default_nettype none

module cmh_field_alu import cmh_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire alu_ctrl_type       ctrl,
   input  wire logic [FIELD_W-1:0] oper_a,
   output logic      [FIELD_W-1:0] acc
);

   logic [FIELD_W-1:0] acc_ff, acc_in;
   logic [FIELD_W:0]   dbl_sum, add_sum, sub_diff;
   logic [FIELD_W+1:0] dbl_diff, add_diff;
   logic [FIELD_W-1:0] dbl_val, base, add_val, sub_val;

   always_comb begin
      // 2r mod p
      dbl_sum  = {acc_ff, 1'b0};
      dbl_diff = {1'b0, dbl_sum} - {2'b00, PRIME};
      dbl_val  = dbl_diff[FIELD_W+1] ? dbl_sum[FIELD_W-1:0] : dbl_diff[FIELD_W-1:0];
      base     = ctrl.dbl ? dbl_val : acc_ff;
      // base + a mod p
      add_sum  = {1'b0, base} + {1'b0, oper_a};
      add_diff = {1'b0, add_sum} - {2'b00, PRIME};
      add_val  = add_diff[FIELD_W+1] ? add_sum[FIELD_W-1:0] : add_diff[FIELD_W-1:0];
      // base - a mod p
      sub_diff = {1'b0, base} - {1'b0, oper_a};
      sub_val  = sub_diff[FIELD_W] ? (sub_diff[FIELD_W-1:0] + PRIME)
                                   : sub_diff[FIELD_W-1:0];
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (!ctrl.step) begin
         acc_in = acc_ff;
      end else if (!ctrl.add_en) begin
         acc_in = base;
      end else if (ctrl.sub) begin
         acc_in = sub_val;
      end else begin
         acc_in = add_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ hdl/cayley_matrix_hash_p128_unit.sv @@
// ----------------------------------------------------------------------------
// cayley_matrix_hash_p128_unit: 2x2 matrix walk hash over GF(2^128 - 15449)
// Words are taken one at a time (req_stall is high outside idle); each bit is worked
// by the shared ALU, which does one double-and-add step per cycle while it steps.
// Last word: then four inversions, then eight digest words.
// Reset: synchronous; matrix returns to identity, all channels idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cayley_matrix_hash_p128_unit_macros.svh"

module cayley_matrix_hash_p128_unit import cmh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_BIT_CHECK, S_BIT_CLR, S_BIT_STEP, S_BIT_SAVE,
      S_INV_START, S_MUL_STEP, S_MUL_SAVE, S_INV_DONE, S_EMIT
   } state_type;

   state_type state_ff;

   // matrix entries column-major: (0,0), (1,0), (0,1), (1,1)
   logic [FIELD_W-1:0] m_ff [4];
   // new entries shift in here during a bit update
   logic [FIELD_W-1:0] n_ff [3];
   logic [FIELD_W-1:0] res_ff;
   logic [7:0]         byte_ff;
   logic [3:0]         bits_left_ff;
   logic               last_ff;
   logic [1:0]         entry_ff;
   logic [1:0]         pos_ff;      // coefficient bit, 2 down to 0
   logic               half_ff;     // second product of a pair / high limb
   logic [6:0]         cnt_ff;      // multiplier bit index
   logic [6:0]         exp_idx_ff;  // exponent bit index
   logic               sq_ff;       // squaring vs multiply by entry
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   alu_ctrl_type       alu_ctrl;
   logic [FIELD_W-1:0] oper_a, acc;
   logic               gen_bit;
   logic [2:0]         mag;
   logic               neg;
   logic [FIELD_W-1:0] sel_m;

   cmh_field_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .oper_a (oper_a),
      .acc    (acc)
   );

   // Control for the shared ALU.
   // Bit update: n[e] = cA*m[e&1] + cB*m[(e&1)+2] by Horner over 3 coefficient
   // bits, the A term with doubling, the B term without.
   // Inversion: left-to-right square-and-multiply, one multiplier bit per step.
   always_comb begin
      gen_bit = byte_ff[7];
      mag     = coef_mag(gen_bit, {entry_ff[1], half_ff});
      neg     = coef_neg(gen_bit, {entry_ff[1], half_ff});
      if (half_ff) begin
         sel_m = entry_ff[0] ? m_ff[3] : m_ff[2];
      end else begin
         sel_m = entry_ff[0] ? m_ff[1] : m_ff[0];
      end
      oper_a   = (state_ff == S_BIT_STEP) ? sel_m : (sq_ff ? res_ff : m_ff[0]);
      alu_ctrl = '0;
      unique case (state_ff)
         S_BIT_CLR, S_INV_START, S_MUL_SAVE: begin
            alu_ctrl.clear = 1'b1;
         end
         S_BIT_STEP: begin
            alu_ctrl.step   = 1'b1;
            alu_ctrl.dbl    = !half_ff;
            alu_ctrl.add_en = mag[pos_ff];
            alu_ctrl.sub    = neg;
         end
         S_MUL_STEP: begin
            alu_ctrl.step   = 1'b1;
            alu_ctrl.dbl    = 1'b1;
            alu_ctrl.add_en = res_ff[cnt_ff];
         end
         default: begin
            alu_ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         m_ff[0]      <= FIELD_W'(1);
         m_ff[1]      <= '0;
         m_ff[2]      <= '0;
         m_ff[3]      <= FIELD_W'(1);
      end else begin
         // in S_EMIT the emit arm owns the valid flag
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  byte_ff      <= req_data.data_byte;
                  bits_left_ff <= (req_data.bit_count > 4'd8) ? 4'd8 : req_data.bit_count;
                  last_ff      <= req_data.last;
                  entry_ff     <= 2'd0;
                  state_ff     <= S_BIT_CHECK;
               end
            end
            S_BIT_CHECK: begin
               if (bits_left_ff == 4'd0) begin
                  state_ff <= last_ff ? S_INV_START : S_IDLE;
               end else begin
                  state_ff <= S_BIT_CLR;
               end
            end
            S_BIT_CLR: begin
               pos_ff   <= 2'd2;
               half_ff  <= 1'b0;
               state_ff <= S_BIT_STEP;
            end
            S_BIT_STEP: begin
               half_ff <= !half_ff;
               if (half_ff) begin
                  if (pos_ff == 2'd0) begin
                     state_ff <= S_BIT_SAVE;
                  end else begin
                     pos_ff <= pos_ff - 2'd1;
                  end
               end
            end
            S_BIT_SAVE: begin
               n_ff[0] <= n_ff[1];
               n_ff[1] <= n_ff[2];
               n_ff[2] <= acc;
               if (entry_ff == 2'd3) begin
                  m_ff[0]      <= n_ff[0];
                  m_ff[1]      <= n_ff[1];
                  m_ff[2]      <= n_ff[2];
                  m_ff[3]      <= acc;
                  byte_ff      <= {byte_ff[6:0], 1'b0};
                  bits_left_ff <= bits_left_ff - 4'd1;
                  entry_ff     <= 2'd0;
                  state_ff     <= S_BIT_CHECK;
               end else begin
                  entry_ff <= entry_ff + 2'd1;
                  state_ff <= S_BIT_CLR;
               end
            end
            S_INV_START: begin
               // entry under inversion always sits in m_ff[0]
               res_ff     <= FIELD_W'(1);
               exp_idx_ff <= 7'd127;
               sq_ff      <= 1'b1;
               cnt_ff     <= 7'd127;
               state_ff   <= S_MUL_STEP;
            end
            S_MUL_STEP: begin
               cnt_ff <= cnt_ff - 7'd1;
               if (cnt_ff == 7'd0) begin
                  state_ff <= S_MUL_SAVE;
               end
            end
            S_MUL_SAVE: begin
               res_ff <= acc;
               cnt_ff <= 7'd127;
               if (sq_ff && INV_EXP[exp_idx_ff]) begin
                  sq_ff    <= 1'b0;
                  state_ff <= S_MUL_STEP;
               end else if (exp_idx_ff == 7'd0) begin
                  state_ff <= S_INV_DONE;
               end else begin
                  exp_idx_ff <= exp_idx_ff - 7'd1;
                  sq_ff      <= 1'b1;
                  state_ff   <= S_MUL_STEP;
               end
            end
            S_INV_DONE: begin
               // rotate so the next entry comes to m_ff[0]
               m_ff[0]  <= m_ff[1];
               m_ff[1]  <= m_ff[2];
               m_ff[2]  <= m_ff[3];
               m_ff[3]  <= res_ff;
               entry_ff <= entry_ff + 2'd1;
               half_ff  <= 1'b0;
               state_ff <= (entry_ff == 2'd3) ? S_EMIT : S_INV_START;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.digest_word <= half_ff ? m_ff[0][127:64] : m_ff[0][63:0];
                  rsp_data_ff.word_index  <= {entry_ff, half_ff};
                  rsp_data_ff.last_word   <= half_ff && (entry_ff == 2'd3);
                  half_ff                 <= !half_ff;
                  if (half_ff) begin
                     entry_ff <= entry_ff + 2'd1;
                     if (entry_ff == 2'd3) begin
                        // digest done: back to identity
                        m_ff[0]  <= FIELD_W'(1);
                        m_ff[1]  <= '0;
                        m_ff[2]  <= '0;
                        m_ff[3]  <= FIELD_W'(1);
                        state_ff <= S_IDLE;
                     end else begin
                        m_ff[0] <= m_ff[1];
                        m_ff[1] <= m_ff[2];
                        m_ff[2] <= m_ff[3];
                        m_ff[3] <= m_ff[0];
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CMH_ASSERT_SAME(a_step_has_bits, clock, reset, (state_ff == S_BIT_STEP), (bits_left_ff != 4'd0), "bit step with no bits left")
   `CMH_ASSERT_SAME(a_last_word_idx, clock, reset, rsp_valid, (rsp_data.last_word == (rsp_data.word_index == 3'd7)), "last word flag mismatch")
   `CMH_ASSERT_SAME(a_rsp_from_emit, clock, reset, $rose(rsp_valid), $past(state_ff == S_EMIT), "digest word outside emit")
   `CMH_ASSERT_NEXT(a_inv_done_next, clock, reset, ((state_ff == S_INV_DONE) && (entry_ff == 2'd3)), (state_ff == S_EMIT), "emit not entered")

endmodule

`default_nettype wire
